### hw/rtl/sidc_pkg.sv
package sidc_pkg;

	localparam int ENTRIES      = 32;
	localparam int MAX_ID_BYTES = 32;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int ID_W   = MAX_ID_BYTES * 8;
	localparam int ENC_W  = 16;
	localparam int LEN_W  = 6;
	localparam int SLOT_W = 5;
	localparam int ROW_W  = ID_W + ENC_W;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_HIT     = 3'd1,
		ST_MISS    = 3'd2,
		ST_ID_LONG = 3'd3,
		ST_ENC_BIG = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_SLOT_RD,
		S_SLOT_WR,
		S_FIN
	} state_t;

endpackage

### hw/rtl/sidc_req_if.sv
interface sidc_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [63:0] id_word0;
	logic [63:0] id_word1;
	logic [63:0] id_word2;
	logic [63:0] id_word3;
	logic [5:0]  id_len;
	logic [15:0] encoding_len;

	modport source (output valid, cmd, id_word0, id_word1, id_word2, id_word3, id_len,
		encoding_len, input ready);
	modport sink (input valid, cmd, id_word0, id_word1, id_word2, id_word3, id_len,
		encoding_len, output ready);
endinterface

### hw/rtl/sidc_rsp_if.sv
interface sidc_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  slot;
	logic [15:0] found_encoding_len;

	modport source (output valid, status, slot, found_encoding_len, input ready);
	modport sink (input valid, status, slot, found_encoding_len, output ready);
endinterface

### hw/rtl/sidc_cfg_if.sv
interface sidc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/sidc_mem.sv
module sidc_mem
	import sidc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [ROW_W-1:0] wr_data
);

	logic [ROW_W-1:0]   mem [ENTRIES];
	logic [ENTRIES-1:0] row_valid_q;
	logic [ROW_W-1:0]   rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A row never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= row_valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/sidc_match.sv
module sidc_match
	import sidc_pkg::*;
(
	input  logic [ID_W-1:0]  row_id,
	input  logic [ID_W-1:0]  query,
	input  logic [LEN_W-1:0] len,
	output logic             match,
	output logic [ID_W-1:0]  cleared,
	output logic [ID_W-1:0]  merged
);

	logic [ID_W-1:0] bit_mask;

	always_comb begin
		for (int b = 0; b < MAX_ID_BYTES; b++) begin
			bit_mask[8*b +: 8] = {8{LEN_W'(b) < len}};
		end
	end

	assign match   = ((row_id ^ query) & bit_mask) == '0;
	assign cleared = row_id & ~bit_mask;
	assign merged  = (row_id & ~bit_mask) | (query & bit_mask);

endmodule

### hw/rtl/session_id_cache_fifo_unit.sv
// An insert scans the table one row per cycle through its read port, clearing the matched ID
// bytes of each matching row through the write port, then does a read-modify-write of the slot.
// A lookup scans until the first hitting row, or through the whole table on a miss.
// Rejected items answer without a scan. One item is in work at a time; the next can be accepted
// in the cycle after the result is loaded. A held result stalls the load.
// Reset clears the table valid bits, the replacement pointer and sets the limit to 4096.
module session_id_cache_fifo_unit
	import sidc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sidc_req_if.sink   req,
	sidc_rsp_if.source rsp,
	sidc_cfg_if.sink   cfg
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_ID_BYTES);

	state_t state_q, state_d;

	logic [ENC_W-1:0]  max_enc_q;
	cmd_t              cmd_q, cmd_d;
	logic [ID_W-1:0]   query_q, query_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [ENC_W-1:0]  enc_q, enc_d;
	logic [IDX_W-1:0]  addr_q, addr_d;
	logic [IDX_W-1:0]  next_slot_q, next_slot_d;
	logic              chk_s1, chk_d;
	logic [IDX_W-1:0]  idx_s1, idx_d;
	status_t           res_status_q, res_status_d;
	logic [SLOT_W-1:0] res_slot_q, res_slot_d;
	logic [ENC_W-1:0]  res_enc_q, res_enc_d;

	logic              out_valid_q, out_valid_d;
	status_t           out_status_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [ENC_W-1:0]  out_enc_q;
	logic              out_load;

	logic [IDX_W-1:0]  rd_addr;
	logic [ROW_W-1:0]  rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ROW_W-1:0]  wr_data;

	logic              match;
	logic [ID_W-1:0]   cleared;
	logic [ID_W-1:0]   merged;
	logic [255:0]      req_id;

	assign req_id = {req.id_word3, req.id_word2, req.id_word1, req.id_word0};

	sidc_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	sidc_match u_match (
		.row_id  (rd_data[ID_W-1:0]),
		.query   (query_q),
		.len     (len_q),
		.match   (match),
		.cleared (cleared),
		.merged  (merged)
	);

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);

	assign rsp.valid              = out_valid_q;
	assign rsp.status             = out_status_q;
	assign rsp.slot               = out_slot_q;
	assign rsp.found_encoding_len = out_enc_q;

	assign rd_addr = (state_q == S_SLOT_RD) ? next_slot_q : addr_q;

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		query_d      = query_q;
		len_d        = len_q;
		enc_d        = enc_q;
		addr_d       = addr_q;
		next_slot_d  = next_slot_q;
		chk_d        = 1'b0;
		idx_d        = idx_s1;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_enc_d    = res_enc_q;
		wr_en        = 1'b0;
		wr_addr      = idx_s1;
		wr_data      = {rd_data[ROW_W-1:ID_W], cleared};
		out_load     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_d        = cmd_t'(req.cmd);
					query_d      = req_id[ID_W-1:0];
					len_d        = req.id_len;
					enc_d        = req.encoding_len;
					addr_d       = '0;
					res_status_d = ST_MISS;
					res_slot_d   = '0;
					res_enc_d    = '0;
					// The encoding limit is checked ahead of the ID length.
					if (cmd_t'(req.cmd) == CMD_INSERT && req.encoding_len > max_enc_q) begin
						res_status_d = ST_ENC_BIG;
						state_d      = S_FIN;
					end else if (req.id_len > MAX_LEN) begin
						res_status_d = ST_ID_LONG;
						state_d      = S_FIN;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				chk_d  = 1'b1;
				idx_d  = addr_q;
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_IDX) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = (cmd_q == CMD_INSERT) ? S_SLOT_RD : S_FIN;
			end
			S_SLOT_RD: begin
				state_d = S_SLOT_WR;
			end
			S_SLOT_WR: begin
				wr_en        = 1'b1;
				wr_addr      = next_slot_q;
				wr_data      = {enc_q, merged};
				res_status_d = ST_STORED;
				res_slot_d   = SLOT_W'(next_slot_q);
				next_slot_d  = (next_slot_q == LAST_IDX) ? '0 : next_slot_q + 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Compare stage: the row read in the previous cycle is checked against the query.
		if (chk_s1 && match) begin
			if (cmd_q == CMD_INSERT) begin
				wr_en = 1'b1;
			end else begin
				res_status_d = ST_HIT;
				res_slot_d   = SLOT_W'(idx_s1);
				res_enc_d    = rd_data[ROW_W-1:ID_W];
				chk_d        = 1'b0;
				state_d      = S_FIN;
			end
		end

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (rsp.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			chk_s1      <= 1'b0;
			next_slot_q <= '0;
			out_valid_q <= 1'b0;
			max_enc_q   <= ENC_W'(4096);
		end else begin
			state_q     <= state_d;
			chk_s1      <= chk_d;
			next_slot_q <= next_slot_d;
			out_valid_q <= out_valid_d;
			if (cfg.valid && cfg.ready) begin
				max_enc_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		query_q      <= query_d;
		len_q        <= len_d;
		enc_q        <= enc_d;
		addr_q       <= addr_d;
		idx_s1       <= idx_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_enc_q    <= res_enc_d;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_enc_q    <= res_enc_q;
		end
	end

endmodule
